/* hw/rtl/brn_pkg.sv */
package brn_pkg;

    // field and register widths
    localparam int CFG_SRC_W   = 9;
    localparam int CFG_OUT_W   = 11;
    localparam int CFG_SCALE_W = 24;
    localparam int POS_W       = 11;
    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int NORM_W      = 16;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // Q9.16 source position: integer part plus 16 fraction bits
    localparam int FRAC_W      = 16;
    localparam int SPOS_W      = CFG_SRC_W + FRAC_W;
    localparam int PROD_W      = POS_W + 1 + CFG_SCALE_W;

    // half a source pixel in Q19.16
    localparam logic [PROD_W-2:0] HALF_PIX = (PROD_W-1)'(32768);

    // 127.5 in Q8.8 and the padding value -32640 as 16-bit two's complement
    localparam logic [NORM_W-1:0] NORM_OFFSET = 16'd32640;
    localparam logic [NORM_W-1:0] PAD_VALUE   = 16'h8080;

    // register map, index i at byte address 4*i
    typedef enum logic [2:0] {
        REG_SRC_WIDTH     = 3'd0,
        REG_SRC_HEIGHT    = 3'd1,
        REG_SCALED_WIDTH  = 3'd2,
        REG_SCALED_HEIGHT = 3'd3,
        REG_INV_SCALE_X   = 3'd4,
        REG_INV_SCALE_Y   = 3'd5
    } reg_idx_t;

    // request kinds
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef struct packed {
        logic             req_type;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_red;
        logic signed [NORM_W-1:0] norm_green;
        logic signed [NORM_W-1:0] norm_blue;
        logic                     padded;
        logic                     bad_position;
    } out_item_t;

endpackage

/* hw/rtl/brn_stream_if.sv */
interface brn_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

/* hw/rtl/brn_ram.sv */
module brn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bilinear_resize_normalize.sv */
// Bilinear scaler with normalization. A load item (req_type 0) writes one RGB pixel into
// the frame store at (pos_x, pos_y) and returns an all-zero item, or bad_position when the
// position lies outside the configured source size; loads are taken one per cycle while
// the result buffer has room. A query item (req_type 1) names an output pixel and returns
// three channels in Q1.15 of (v-127.5)/128, or -32640 with padded set when it lies outside
// the resized area. An interpolated query reads its four neighbor pixels one after another
// from the single-port frame memory, and the next item waits until those reads are issued;
// padded queries make no memory access. Up to eight results are buffered, so the block
// keeps accepting items while the result side stalls, until eight results are held. The
// frame store has no clearing pass: a query that touches a pixel never loaded returns
// undefined channel values. Registers (APB, byte address 4*i): 0 src_width, 1 src_height,
// 2 scaled width, 3 scaled height, 4 inv_scale_x, 5 inv_scale_y; write them only while
// no item is in flight.
module bilinear_resize_normalize #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_OUT_SIZE   = 1280
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brn_pkg::PADDR_W-1:0]     paddr,
    input  logic [brn_pkg::PDATA_W-1:0]     pwdata,
    output logic [brn_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    brn_stream_if.sink                      request,
    brn_stream_if.source                    result
);

    import brn_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int FIFO_DEPTH  = 8;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_SRC_W-1:0] SW_CAP =
        (MAX_SRC_WIDTH > 511) ? 9'd511 : CFG_SRC_W'(MAX_SRC_WIDTH);
    localparam logic [CFG_SRC_W-1:0] SH_CAP =
        (MAX_SRC_HEIGHT > 511) ? 9'd511 : CFG_SRC_W'(MAX_SRC_HEIGHT);
    localparam logic [CFG_OUT_W-1:0] RS_CAP   = CFG_OUT_W'(MAX_OUT_SIZE);
    localparam logic [AW-1:0]        ROW_STRIDE = AW'(MAX_SRC_WIDTH);

    // neighbor read order: top-left, top-right, bottom-left, bottom-right
    localparam logic [1:0] PH_TL = 2'd0;
    localparam logic [1:0] PH_TR = 2'd1;
    localparam logic [1:0] PH_BL = 2'd2;
    localparam logic [1:0] PH_BR = 2'd3;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_BAD    = 2'd1,
        KIND_PAD    = 2'd2,
        KIND_INTERP = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             last;
        logic [1:0]       phase;
        logic [PIX_W-1:0] ty;
    } tag_t;

    // Q9.16 source coordinate along one axis, clamped to [0, size-1]
    function automatic logic [SPOS_W-1:0] src_axis(input logic [PROD_W-1:0] prod,
                                                   input logic [CFG_SRC_W-1:0] size);
        logic [PROD_W-2:0] t;
        logic [PROD_W-2:0] s;
        logic [SPOS_W-1:0] maxp;
        begin
            t    = prod[PROD_W-1:1];
            maxp = {size - 9'd1, {FRAC_W{1'b0}}};
            s    = t - HALF_PIX;
            if (t < HALF_PIX)
            begin
                return '0;
            end
            else if (s > (PROD_W-1)'(maxp))
            begin
                return maxp;
            end
            return s[SPOS_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    logic [CFG_SRC_W-1:0]   src_width_reg, src_height_reg;
    logic [CFG_OUT_W-1:0]   out_width_reg, out_height_reg;
    logic [CFG_SCALE_W-1:0] inv_scale_x_reg, inv_scale_y_reg;
    logic                   cfg_we;
    reg_idx_t               cfg_idx;

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= 9'd256;
            src_height_reg  <= 9'd256;
            out_width_reg   <= 11'd256;
            out_height_reg  <= 11'd256;
            inv_scale_x_reg <= 24'd65536;
            inv_scale_y_reg <= 24'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SRC_WIDTH:     src_width_reg   <= pwdata[CFG_SRC_W-1:0];
                REG_SRC_HEIGHT:    src_height_reg  <= pwdata[CFG_SRC_W-1:0];
                REG_SCALED_WIDTH:  out_width_reg   <= pwdata[CFG_OUT_W-1:0];
                REG_SCALED_HEIGHT: out_height_reg  <= pwdata[CFG_OUT_W-1:0];
                REG_INV_SCALE_X:   inv_scale_x_reg <= pwdata[CFG_SCALE_W-1:0];
                REG_INV_SCALE_Y:   inv_scale_y_reg <= pwdata[CFG_SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_SRC_WIDTH:     prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT:    prdata = PDATA_W'(src_height_reg);
            REG_SCALED_WIDTH:  prdata = PDATA_W'(out_width_reg);
            REG_SCALED_HEIGHT: prdata = PDATA_W'(out_height_reg);
            REG_INV_SCALE_X:   prdata = PDATA_W'(inv_scale_x_reg);
            REG_INV_SCALE_Y:   prdata = PDATA_W'(inv_scale_y_reg);
            default:           prdata = '0;
        endcase
    end

    // effective sizes
    logic [CFG_SRC_W-1:0] sw_eff, sh_eff;
    logic [CFG_OUT_W-1:0] rw_eff, rh_eff;

    always_comb
    begin
        sw_eff = (src_width_reg == '0) ? 9'd1 :
                 (src_width_reg > SW_CAP) ? SW_CAP : src_width_reg;
        sh_eff = (src_height_reg == '0) ? 9'd1 :
                 (src_height_reg > SH_CAP) ? SH_CAP : src_height_reg;
        rw_eff = (out_width_reg > RS_CAP) ? RS_CAP : out_width_reg;
        rh_eff = (out_height_reg > RS_CAP) ? RS_CAP : out_height_reg;
    end

    // ------------------------------------------------------------------
    // front pipeline: s1 holds the item, s2 the scale products, s3 the neighbors
    logic                   s1_valid_reg, s1_valid_next;
    in_item_t               s1_item_reg;
    logic                   s2_valid_reg, s2_valid_next;
    kind_t                  s2_kind_reg;
    logic [PROD_W-1:0]      s2_prod_x_reg, s2_prod_y_reg;
    logic [CFG_SRC_W-1:0]   s2_px_reg, s2_py_reg;
    logic [RGB_W-1:0]       s2_rgb_reg;
    logic                   s3_valid_reg, s3_valid_next;
    kind_t                  s3_kind_reg;
    logic [CFG_SRC_W-1:0]   s3_xa_reg, s3_xb_reg, s3_ya_reg, s3_yb_reg;
    logic [PIX_W-1:0]       s3_tx_reg, s3_ty_reg;
    logic [RGB_W-1:0]       s3_rgb_reg;

    logic in_fire, s1_move, s2_move, s3_done;
    logic s1_free, s2_free, s3_free;

    assign s3_free = !s3_valid_reg || s3_done;
    assign s2_move = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s2_move;
    assign s1_move = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_move;

    assign request.ready = s1_free;
    assign in_fire       = request.valid && s1_free;

    // stage 1 -> 2: classify and multiply by the inverse scale
    kind_t             s2_kind_next;
    logic [PROD_W-1:0] prod_x, prod_y;

    always_comb
    begin
        if (s1_item_reg.req_type == REQ_QUERY)
        begin
            s2_kind_next = (s1_item_reg.pos_x >= rw_eff || s1_item_reg.pos_y >= rh_eff) ?
                           KIND_PAD : KIND_INTERP;
        end
        else
        begin
            s2_kind_next = (s1_item_reg.pos_x >= POS_W'(sw_eff) ||
                            s1_item_reg.pos_y >= POS_W'(sh_eff)) ? KIND_BAD : KIND_WRITE;
        end
        prod_x = {s1_item_reg.pos_x, 1'b1} * inv_scale_x_reg;
        prod_y = {s1_item_reg.pos_y, 1'b1} * inv_scale_y_reg;
    end

    // stage 2 -> 3: source position, weights and clamped neighbors
    logic [SPOS_W-1:0]    fx, fy;
    logic [CFG_SRC_W-1:0] x0, y0, x1, y1;
    logic [CFG_SRC_W-1:0] xa_next, ya_next;

    always_comb
    begin
        fx = src_axis(s2_prod_x_reg, sw_eff);
        fy = src_axis(s2_prod_y_reg, sh_eff);
        x0 = fx[SPOS_W-1:FRAC_W];
        y0 = fy[SPOS_W-1:FRAC_W];
        x1 = ({1'b0, x0} + 10'd1 < {1'b0, sw_eff}) ? x0 + 9'd1 : sw_eff - 9'd1;
        y1 = ({1'b0, y0} + 10'd1 < {1'b0, sh_eff}) ? y0 + 9'd1 : sh_eff - 9'd1;
        xa_next = (s2_kind_reg == KIND_INTERP) ? x0 : s2_px_reg;
        ya_next = (s2_kind_reg == KIND_INTERP) ? y0 : s2_py_reg;
    end

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
        s3_valid_next = s2_move ? 1'b1 : (s3_done ? 1'b0 : s3_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= request.payload;
        end
        if (s1_move)
        begin
            s2_kind_reg   <= s2_kind_next;
            s2_prod_x_reg <= prod_x;
            s2_prod_y_reg <= prod_y;
            s2_px_reg     <= s1_item_reg.pos_x[CFG_SRC_W-1:0];
            s2_py_reg     <= s1_item_reg.pos_y[CFG_SRC_W-1:0];
            s2_rgb_reg    <= {s1_item_reg.red, s1_item_reg.green, s1_item_reg.blue};
        end
        if (s2_move)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_xa_reg   <= xa_next;
            s3_xb_reg   <= x1;
            s3_ya_reg   <= ya_next;
            s3_yb_reg   <= y1;
            s3_tx_reg   <= fx[FRAC_W-1:FRAC_W-PIX_W];
            s3_ty_reg   <= fy[FRAC_W-1:FRAC_W-PIX_W];
            s3_rgb_reg  <= s2_rgb_reg;
        end
    end

    // ------------------------------------------------------------------
    // frame store access: one read or write per cycle; a new item waits for a free result credit
    logic [1:0]        phase_reg, phase_next;
    logic [FCNT_W-1:0] cred_cnt_reg, cred_cnt_next;
    logic              cred_ok, iss_fire, iss_last, iss_start;
    logic              ram_en, ram_we;
    logic [AW-1:0]     ram_addr;
    logic [RGB_W-1:0]  ram_rdata;
    logic [CFG_SRC_W-1:0] x_sel, y_sel;
    logic              out_fire;

    assign cred_ok   = cred_cnt_reg < FCNT_W'(FIFO_DEPTH);
    assign iss_fire  = s3_valid_reg && (phase_reg != PH_TL || cred_ok);
    assign iss_start = iss_fire && phase_reg == PH_TL;
    assign iss_last  = s3_kind_reg != KIND_INTERP || phase_reg == PH_BR;
    assign s3_done   = iss_fire && iss_last;

    always_comb
    begin
        x_sel    = phase_reg[0] ? s3_xb_reg : s3_xa_reg;
        y_sel    = phase_reg[1] ? s3_yb_reg : s3_ya_reg;
        ram_addr = AW'(y_sel) * ROW_STRIDE + AW'(x_sel);
        ram_en   = iss_fire && (s3_kind_reg == KIND_INTERP || s3_kind_reg == KIND_WRITE);
        ram_we   = s3_kind_reg == KIND_WRITE;
        phase_next = iss_fire ? (iss_last ? PH_TL : phase_reg + 2'd1) : phase_reg;
        cred_cnt_next = cred_cnt_reg + FCNT_W'(iss_start) - FCNT_W'(out_fire);
    end

    brn_ram #(
        .WIDTH (RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s3_rgb_reg),
        .rdata (ram_rdata)
    );

    // tag that travels with the read data
    logic             tag_valid_reg;
    tag_t             tag_reg;
    logic [PIX_W-1:0] tag_tx_reg;

    always_ff @(posedge clk)
    begin
        if (iss_fire)
        begin
            tag_reg.kind  <= s3_kind_reg;
            tag_reg.last  <= iss_last;
            tag_reg.phase <= phase_reg;
            tag_reg.ty    <= s3_ty_reg;
            tag_tx_reg    <= s3_tx_reg;
        end
    end

    // ------------------------------------------------------------------
    // gather neighbors and blend horizontally
    logic [RGB_W-1:0]  pix_a_reg, pix_b_reg, pix_d_reg;
    logic              l1_valid_reg;
    kind_t             l1_kind_reg;
    logic [PIX_W-1:0]  l1_ty_reg;
    logic [15:0]       l1_top_reg [3];
    logic [15:0]       l1_bot_reg [3];
    logic [15:0]       top_next [3];
    logic [15:0]       bot_next [3];

    always_ff @(posedge clk)
    begin
        if (tag_valid_reg && tag_reg.kind == KIND_INTERP && !tag_reg.last)
        begin
            case (tag_reg.phase)
                PH_TL:   pix_a_reg <= ram_rdata;
                PH_TR:   pix_b_reg <= ram_rdata;
                PH_BL:   pix_d_reg <= ram_rdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [8:0]  w1, w0;
        logic [16:0] st, sb;
        w1 = {1'b0, tag_tx_reg};
        w0 = 9'd256 - w1;
        for (int c = 0; c < 3; c++)
        begin
            st = pix_a_reg[PIX_W*(2-c) +: PIX_W] * w0 + pix_b_reg[PIX_W*(2-c) +: PIX_W] * w1;
            sb = pix_d_reg[PIX_W*(2-c) +: PIX_W] * w0 + ram_rdata[PIX_W*(2-c) +: PIX_W] * w1;
            top_next[c] = st[15:0];
            bot_next[c] = sb[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_valid_reg && tag_reg.last)
        begin
            l1_kind_reg <= tag_reg.kind;
            l1_ty_reg   <= tag_reg.ty;
            l1_top_reg  <= top_next;
            l1_bot_reg  <= bot_next;
        end
    end

    // vertical blend, offset and result formatting
    out_item_t  res_next;
    logic [15:0] norm [3];

    always_comb
    begin
        logic [8:0]  w1, w0;
        logic [24:0] acc;
        w1 = {1'b0, l1_ty_reg};
        w0 = 9'd256 - w1;
        for (int c = 0; c < 3; c++)
        begin
            acc     = l1_top_reg[c] * w0 + l1_bot_reg[c] * w1;
            norm[c] = acc[23:8] - NORM_OFFSET;
        end
        res_next = '0;
        case (l1_kind_reg)
            KIND_INTERP:
            begin
                res_next.norm_red   = norm[0];
                res_next.norm_green = norm[1];
                res_next.norm_blue  = norm[2];
            end
            KIND_PAD:
            begin
                res_next.norm_red   = PAD_VALUE;
                res_next.norm_green = PAD_VALUE;
                res_next.norm_blue  = PAD_VALUE;
                res_next.padded     = 1'b1;
            end
            KIND_BAD:
            begin
                res_next.bad_position = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result buffer
    out_item_t         fifo_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic              fifo_push;

    assign fifo_push      = l1_valid_reg;
    assign result.valid   = fifo_cnt_reg != '0;
    assign result.payload = fifo_mem[rd_ptr_reg];
    assign out_fire       = result.valid && result.ready;

    always_comb
    begin
        wr_ptr_next   = fifo_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = out_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg + FCNT_W'(fifo_push) - FCNT_W'(out_fire);
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem[wr_ptr_reg] <= res_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            phase_reg     <= PH_TL;
            cred_cnt_reg  <= '0;
            tag_valid_reg <= 1'b0;
            l1_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fifo_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            phase_reg     <= phase_next;
            cred_cnt_reg  <= cred_cnt_next;
            tag_valid_reg <= iss_fire;
            l1_valid_reg  <= tag_valid_reg && tag_reg.last;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fifo_cnt_reg  <= fifo_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // checks
    a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cred_cnt_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result credit count above buffer depth");

    a_fifo_in_cred: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= cred_cnt_reg)
        else $error("buffered results exceed reserved credits");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_cnt_reg < FCNT_W'(FIFO_DEPTH)) || out_fire)
        else $error("result buffer written while full");

    a_reads_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg && tag_reg.kind == KIND_INTERP && !tag_reg.last
        |=> tag_valid_reg && tag_reg.phase == $past(tag_reg.phase) + 2'd1)
        else $error("neighbor reads of a query not issued in consecutive cycles");

endmodule

/* dv/resize_norm_checker.sv */
`timescale 1ns / 100ps

module resize_norm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brn_pkg::PADDR_W-1:0] paddr,
    input  logic [brn_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    brn_stream_if                       request,
    brn_stream_if                       result,
    output int                          mismatches,
    output int                          expected_left
);

    import brn_pkg::*;

    localparam int SRC_MAX_W   = 256;
    localparam int SRC_MAX_H   = 256;
    localparam int OUT_MAX     = 1280;

    // shadow of the register file
    logic [CFG_SRC_W-1:0]   src_w;
    logic [CFG_SRC_W-1:0]   src_h;
    logic [CFG_OUT_W-1:0]   out_w;
    logic [CFG_OUT_W-1:0]   out_h;
    logic [CFG_SCALE_W-1:0] scale_x;
    logic [CFG_SCALE_W-1:0] scale_y;

    // own copy of the frame store, {red, green, blue}
    logic [RGB_W-1:0] pixel_mem [SRC_MAX_W*SRC_MAX_H];

    out_item_t pending_outputs[$];
    int        err_count;
    in_item_t  req;
    out_item_t got;
    out_item_t want;

    function automatic int unsigned eff_src_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q8.16 source coordinate for output coordinate p along one axis
    function automatic longint unsigned source_coord(int unsigned p, int unsigned scale,
                                                     int unsigned size);
        longint unsigned pl;
        longint unsigned t;
        longint unsigned last_pos;
        pl = p;
        t = ((pl * 2 + 1) * scale) >> 1;
        last_pos = size - 1;
        last_pos = last_pos << 16;
        if (t < 32768) return 0;
        t = t - 32768;
        return (t > last_pos) ? last_pos : t;
    endfunction

    // two-stage lerp with 8-bit weights, Q8.8 result minus 127.5
    function automatic logic [NORM_W-1:0] blend_channel(int unsigned a, int unsigned b,
                                                        int unsigned d, int unsigned e,
                                                        int unsigned tx, int unsigned ty);
        int unsigned upper;
        int unsigned lower;
        int unsigned q8;
        upper = a * (256 - tx) + b * tx;
        lower = d * (256 - tx) + e * tx;
        q8 = (upper * (256 - ty) + lower * ty) >> 8;
        return NORM_W'(q8 - 32'(NORM_OFFSET));
    endfunction

    function automatic out_item_t predict_query(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        out_item_t       r;
        int unsigned     sw, sh, rw, rh;
        int unsigned     x0, x1, y0, y1, tx, ty;
        longint unsigned fx, fy;
        logic [RGB_W-1:0] p00, p01, p10, p11;
        r = '0;
        sw = eff_src_size(src_w, SRC_MAX_W);
        sh = eff_src_size(src_h, SRC_MAX_H);
        rw = (out_w > OUT_MAX) ? OUT_MAX : out_w;
        rh = (out_h > OUT_MAX) ? OUT_MAX : out_h;
        if (px >= rw || py >= rh)
        begin
            r.norm_red   = PAD_VALUE;
            r.norm_green = PAD_VALUE;
            r.norm_blue  = PAD_VALUE;
            r.padded     = 1'b1;
            return r;
        end
        fx = source_coord(px, scale_x, sw);
        fy = source_coord(py, scale_y, sh);
        x0 = 32'(fx >> 16);
        y0 = 32'(fy >> 16);
        tx = 32'((fx >> 8) & 8'hFF);
        ty = 32'((fy >> 8) & 8'hFF);
        x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
        y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
        p00 = pixel_mem[y0 * SRC_MAX_W + x0];
        p01 = pixel_mem[y0 * SRC_MAX_W + x1];
        p10 = pixel_mem[y1 * SRC_MAX_W + x0];
        p11 = pixel_mem[y1 * SRC_MAX_W + x1];
        r.norm_red   = blend_channel(p00[23:16], p01[23:16], p10[23:16], p11[23:16], tx, ty);
        r.norm_green = blend_channel(p00[15:8], p01[15:8], p10[15:8], p11[15:8], tx, ty);
        r.norm_blue  = blend_channel(p00[7:0], p01[7:0], p10[7:0], p11[7:0], tx, ty);
        return r;
    endfunction

    // loads update the store here, so later queries see them in order
    function automatic out_item_t predict_item(in_item_t it);
        out_item_t   r;
        int unsigned sw, sh;
        r = '0;
        if (req_type_t'(it.req_type) == REQ_QUERY) return predict_query(it.pos_x, it.pos_y);
        sw = eff_src_size(src_w, SRC_MAX_W);
        sh = eff_src_size(src_h, SRC_MAX_H);
        if (it.pos_x >= sw || it.pos_y >= sh)
            r.bad_position = 1'b1;
        else
            pixel_mem[it.pos_y * SRC_MAX_W + it.pos_x] = {it.red, it.green, it.blue};
        return r;
    endfunction

    task automatic check_field(string name, logic signed [NORM_W:0] exp_v,
                               logic signed [NORM_W:0] act_v);
        if (exp_v !== act_v)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    // register writes, input items and result items, all sampled at the edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w   = 9'd256;
            src_h   = 9'd256;
            out_w   = 11'd256;
            out_h   = 11'd256;
            scale_x = 24'd65536;
            scale_y = 24'd65536;
            pending_outputs.delete();
            err_count = 0;
            mismatches    <= 0;
            expected_left <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_SRC_WIDTH:     src_w   = pwdata[CFG_SRC_W-1:0];
                    REG_SRC_HEIGHT:    src_h   = pwdata[CFG_SRC_W-1:0];
                    REG_SCALED_WIDTH:  out_w   = pwdata[CFG_OUT_W-1:0];
                    REG_SCALED_HEIGHT: out_h   = pwdata[CFG_OUT_W-1:0];
                    REG_INV_SCALE_X:   scale_x = pwdata[CFG_SCALE_W-1:0];
                    REG_INV_SCALE_Y:   scale_y = pwdata[CFG_SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (request.valid && request.ready)
            begin
                req = request.payload;
                pending_outputs.insert(pending_outputs.size(), predict_item(req));
            end

            if (result.valid && result.ready)
            begin
                got = result.payload;
                if (pending_outputs.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected item: expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    check_field("norm_red", want.norm_red, got.norm_red);
                    check_field("norm_green", want.norm_green, got.norm_green);
                    check_field("norm_blue", want.norm_blue, got.norm_blue);
                    check_field("padded", want.padded, got.padded);
                    check_field("bad_position", want.bad_position, got.bad_position);
                end
            end

            mismatches    <= err_count;
            expected_left <= pending_outputs.size();
        end
    end

endmodule

/* dv/bilinear_resize_normalize_tb.sv */
`timescale 1ns / 100ps

module bilinear_resize_normalize_tb;
    import brn_pkg::*;

    localparam int SRC_MAX        = 256;
    localparam int OUT_MAX        = 1280;
    localparam int NUM_PHASES     = 14;
    localparam int RAND_PER_PHASE = 55;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_NS     = 2000000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    brn_stream_if #(.payload_t(in_item_t))  request_ch ();
    brn_stream_if #(.payload_t(out_item_t)) result_ch ();

    int mismatches;
    int expected_left;

    // effective sizes as the block sees them
    int unsigned cur_sw, cur_sh, cur_rw, cur_rh;
    // store entries written so far; queries only touch written pixels
    bit loaded [SRC_MAX*SRC_MAX];
    int send_calm;
    int recv_calm;

    always #1 clk = ~clk;

    bilinear_resize_normalize dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (request_ch),
        .result  (result_ch)
    );

    resize_norm_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .request       (request_ch),
        .result        (result_ch),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    function automatic int unsigned eff_src(int unsigned raw);
        if (raw == 0) return 1;
        return (raw > SRC_MAX) ? SRC_MAX : raw;
    endfunction

    function automatic int unsigned eff_out(int unsigned raw);
        return (raw > OUT_MAX) ? OUT_MAX : raw;
    endfunction

    // mostly the true ratio, sometimes any 24-bit value
    function automatic int unsigned pick_scale(int unsigned src_sz, int unsigned out_sz);
        int unsigned ratio;
        if (out_sz == 0 || $urandom_range(0, 4) == 0) return $urandom & 24'hFFFFFF;
        ratio = (src_sz << 16) / out_sz;
        return (ratio > 24'hFFFFFF) ? 24'hFFFFFF : ratio;
    endfunction

    function automatic in_item_t make_load(int unsigned x, int unsigned y,
                                           logic [RGB_W-1:0] rgb);
        in_item_t it;
        it.req_type = REQ_LOAD;
        it.pos_x    = POS_W'(x);
        it.pos_y    = POS_W'(y);
        it.red      = rgb[23:16];
        it.green    = rgb[15:8];
        it.blue     = rgb[7:0];
        return it;
    endfunction

    function automatic in_item_t make_query(int unsigned x, int unsigned y);
        in_item_t it;
        it = make_load(x, y, RGB_W'($urandom));
        it.req_type = REQ_QUERY;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(10, 60);
        end
        if (gap != 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid   <= 1'b1;
        request_ch.payload <= it;
        @(posedge clk);
        while (!request_ch.ready) @(posedge clk);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain(int extra);
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // fill every pixel of the current source region not yet written
    task automatic load_region();
        for (int y = 0; y < cur_sh; y++)
            for (int x = 0; x < cur_sw; x++)
                if (!loaded[y*SRC_MAX + x])
                begin
                    send_item(make_load(x, y, RGB_W'($urandom)));
                    loaded[y*SRC_MAX + x] = 1'b1;
                end
    endtask

    task automatic apply_setup(int unsigned sw_raw, int unsigned sh_raw, int unsigned rw_raw,
                               int unsigned rh_raw, int unsigned sx, int unsigned sy);
        drain(DRAIN_CYCLES);
        apb_write(REG_SRC_WIDTH, sw_raw);
        apb_write(REG_SRC_HEIGHT, sh_raw);
        apb_write(REG_SCALED_WIDTH, rw_raw);
        apb_write(REG_SCALED_HEIGHT, rh_raw);
        apb_write(REG_INV_SCALE_X, sx);
        apb_write(REG_INV_SCALE_Y, sy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_sw = eff_src(sw_raw & 9'h1FF);
        cur_sh = eff_src(sh_raw & 9'h1FF);
        cur_rw = eff_out(rw_raw & 11'h7FF);
        cur_rh = eff_out(rh_raw & 11'h7FF);
        load_region();
    endtask

    task automatic run_random(int n);
        in_item_t    it;
        int          hold_at;
        int          roll;
        int unsigned x, y;
        hold_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at) drain(0);
            roll = $urandom_range(0, 99);
            if (roll < 20)
            begin
                // load inside the source region
                x = $urandom_range(0, cur_sw - 1);
                y = $urandom_range(0, cur_sh - 1);
                it = make_load(x, y, RGB_W'($urandom));
                loaded[y*SRC_MAX + x] = 1'b1;
            end
            else if (roll < 28)
            begin
                // load anywhere, mostly flagged as bad
                x = $urandom_range(0, 2047);
                y = $urandom_range(0, 2047);
                it = make_load(x, y, RGB_W'($urandom));
                if (x < cur_sw && y < cur_sh) loaded[y*SRC_MAX + x] = 1'b1;
            end
            else if (roll < 36)
            begin
                // query on the border of the resized area, either side
                case ($urandom_range(0, 2))
                    0: x = 0;
                    1: x = cur_rw - 1;
                    default: x = cur_rw;
                endcase
                case ($urandom_range(0, 2))
                    0: y = 0;
                    1: y = cur_rh - 1;
                    default: y = cur_rh;
                endcase
                it = make_query(x & 11'h7FF, y & 11'h7FF);
            end
            else if (roll < 90 && cur_rw > 0 && cur_rh > 0)
            begin
                it = make_query($urandom_range(0, cur_rw - 1), $urandom_range(0, cur_rh - 1));
            end
            else
            begin
                it = make_query($urandom_range(0, 2047), $urandom_range(0, 2047));
            end
            send_item(it);
        end
    endtask

    // result side: random stall before each item, with calm stretches
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        recv_calm = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (recv_calm > 0)
            begin
                recv_calm--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 31) == 0) recv_calm = $urandom_range(10, 60);
            end
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        int unsigned sw_raw, sh_raw, rw_raw, rh_raw;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        request_ch.valid   <= 1'b0;
        request_ch.payload <= '0;
        send_calm = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3 source doubled, extreme pixels, corners, padding, bad loads
        apply_setup(3, 3, 6, 6, 24'h8000, 24'h8000);
        send_item(make_load(0, 0, 24'hFFFFFF));
        send_item(make_load(2, 2, 24'h000000));
        send_item(make_load(1, 1, 24'hFF00FF));
        send_item(make_load(2, 0, 24'h00FF00));
        send_item(make_query(0, 0));
        send_item(make_query(5, 5));
        send_item(make_query(5, 0));
        send_item(make_query(0, 5));
        send_item(make_query(2, 3));
        send_item(make_query(6, 0));
        send_item(make_query(0, 6));
        send_item(make_query(2047, 2047));
        send_item(make_load(3, 0, 24'h123456));
        send_item(make_load(0, 3, 24'h654321));
        send_item(make_load(2047, 2047, 24'hFFFFFF));
        run_random(RAND_PER_PHASE);

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            case (p)
                // widest source and widest output
                1: apply_setup(256, 2, 1280, 3, pick_scale(256, 1280), pick_scale(2, 3));
                // tallest source and tallest output
                2: apply_setup(2, 256, 5, 1280, pick_scale(2, 5), pick_scale(256, 1280));
                // zero resized width: everything padded
                3: apply_setup(1, 1, 0, 4, 24'h10000, 24'h10000);
                // zero source sizes, saturated output sizes, zero inverse scale
                4: apply_setup(0, 0, 2047, 2047, 0, 0);
                5: apply_setup(511, 2, 300, 9, 24'hFFFFFF, 1);
                6: apply_setup(3, 5, 7, 1, 1, 24'hFFFFFF);
                default:
                begin
                    sw_raw = $urandom_range(1, 16);
                    sh_raw = $urandom_range(1, 16);
                    rw_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047)
                                                         : $urandom_range(1, 64);
                    rh_raw = $urandom_range(1, 64);
                    apply_setup(sw_raw, sh_raw, rw_raw, rh_raw,
                                pick_scale(sw_raw, eff_out(rw_raw)),
                                pick_scale(sh_raw, eff_out(rh_raw)));
                end
            endcase
            run_random(RAND_PER_PHASE);
        end

        drain(DRAIN_CYCLES);
        if (mismatches == 0 && expected_left == 0)
            $display("** bilinear_resize_normalize: PASSED **");
        else
            $display("** bilinear_resize_normalize: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("** bilinear_resize_normalize: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/brn_pkg.sv
hw/rtl/brn_stream_if.sv
hw/rtl/brn_ram.sv
hw/rtl/bilinear_resize_normalize.sv
dv/resize_norm_checker.sv
dv/bilinear_resize_normalize_tb.sv
